FILE: rtl/cdfre_pkg.sv
// ----------------------------------------------------------------------------
// cdfre_pkg
// Shared types and codes of the cdf range encoder with escape coding.
// ----------------------------------------------------------------------------
package cdfre_pkg;

  // input opcodes
  localparam logic [1:0] OP_CDF = 2'd0;
  localparam logic [1:0] OP_LEN = 2'd1;
  localparam logic [1:0] OP_ENC = 2'd2;
  localparam logic [1:0] OP_FIN = 2'd3;

  // configuration register indexes
  localparam logic REG_PREC = 1'b0;
  localparam logic REG_ESC  = 1'b1;

  // command from the sequencer to the interval coder
  typedef struct packed {
    logic        start;
    logic        finish;
    logic [16:0] lo;
    logic [16:0] hi;
    logic [4:0]  prec;
  } cdfre_cmd_t;

  // one output item offered by the interval coder
  typedef struct packed {
    logic        valid;
    logic [7:0]  data;
    logic [15:0] rep;
  } cdfre_emit_t;

endpackage

FILE: rtl/cdfre_ram.sv
// ----------------------------------------------------------------------------
// cdfre_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cdfre_ram #(
  parameter int W = 8,
  parameter int D = 64,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/cdfre_coder.sv
// ----------------------------------------------------------------------------
// cdfre_coder
// Interval coder: scales low and range by one symbol, renormalizes 16 bits,
// defers carries, flushes on finish, offers produced bytes one at a time.
// ----------------------------------------------------------------------------
module cdfre_coder (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cdfre_pkg::cdfre_cmd_t cmd,
  input  logic                  emit_ok,
  output cdfre_pkg::cdfre_emit_t emit,
  output logic                  done
);
  import cdfre_pkg::*;

  typedef enum logic [5:0] {
    C_IDLE = 6'b000001,
    C_MULA = 6'b000010,
    C_MULB = 6'b000100,
    C_UPD  = 6'b001000,
    C_DEC  = 6'b010000,
    C_EMIT = 6'b100000
  } cst_t;

  cst_t         st_r, st_nxt;
  logic [31:0]  low_r, low_nxt;
  logic [31:0]  rng_r, rng_nxt;
  logic [15:0]  pw_r, pw_nxt;
  logic [15:0]  run_r, run_nxt;
  logic         wrap_r, wrap_nxt;
  logic [16:0]  lo_r, lo_nxt;
  logic [16:0]  hi_r, hi_nxt;
  logic [4:0]   prec_r, prec_nxt;
  logic [32:0]  size_r, size_nxt;
  logic [49:0]  prod_r, prod_nxt;
  logic [31:0]  a_r, a_nxt;
  logic [7:0]   sb_r [5];
  logic [7:0]   sb_nxt [5];
  logic [15:0]  sr_r [5];
  logic [15:0]  sr_nxt [5];
  logic [2:0]   cnt_r, cnt_nxt;
  logic [2:0]   idx_r, idx_nxt;

  // step sequencing and interval arithmetic
  always_comb begin
    logic [16:0] full;
    logic [16:0] l;
    logic [16:0] h;
    logic [15:0] mid;
    logic [31:0] b;
    logic [31:0] lown;
    logic [32:0] sum;
    logic [15:0] w;
    logic [7:0]  fill;
    logic [15:0] top;
    logic [31:0] nl;
    logic [31:0] nr;
    logic [2:0]  k;
    st_nxt   = st_r;
    low_nxt  = low_r;
    rng_nxt  = rng_r;
    pw_nxt   = pw_r;
    run_nxt  = run_r;
    wrap_nxt = wrap_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    prec_nxt = prec_r;
    size_nxt = size_r;
    prod_nxt = prod_r;
    a_nxt    = a_r;
    sb_nxt   = sb_r;
    sr_nxt   = sr_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    done     = 1'b0;
    emit     = '0;
    full = '0; l = '0; h = '0; mid = '0; b = '0; lown = '0; sum = '0;
    w = '0; fill = '0; top = '0; nl = '0; nr = '0; k = '0;
    unique case (st_r)
      C_IDLE: begin
        if (cmd.start) begin
          // saturate the bounds into the precision
          full = 17'd1 << cmd.prec;
          l = (cmd.lo > full) ? full : cmd.lo;
          h = (cmd.hi > full) ? full : cmd.hi;
          if (h <= l) begin
            if (l >= full) begin
              l = full - 17'd1;
              h = full;
            end else begin
              h = l + 17'd1;
            end
          end
          lo_nxt   = l;
          hi_nxt   = h;
          prec_nxt = cmd.prec;
          size_nxt = {1'b0, rng_r} + 33'd1;
          st_nxt   = C_MULA;
        end else if (cmd.finish) begin
          // flush the interval, then clear the coder
          if (pw_r != 16'd0) begin
            sb_nxt[k] = pw_r[15:8];
            sr_nxt[k] = 16'd1;
            k = k + 3'd1;
            if (pw_r[7:0] != 8'd0) begin
              sb_nxt[k] = pw_r[7:0];
              sr_nxt[k] = 16'd1;
              k = k + 3'd1;
            end
          end else if (low_r != 32'd0) begin
            mid = 16'((low_r - 32'd1) >> 16) + 16'd1;
            sb_nxt[k] = mid[15:8];
            sr_nxt[k] = 16'd1;
            k = k + 3'd1;
            if (mid[7:0] != 8'd0) begin
              sb_nxt[k] = mid[7:0];
              sr_nxt[k] = 16'd1;
              k = k + 3'd1;
            end
          end
          low_nxt = '0;
          rng_nxt = '1;
          pw_nxt  = '0;
          run_nxt = '0;
          cnt_nxt = k;
          idx_nxt = '0;
          st_nxt  = C_EMIT;
        end
      end
      C_MULA: begin
        prod_nxt = size_r * lo_r;
        st_nxt   = C_MULB;
      end
      C_MULB: begin
        a_nxt    = 32'(prod_r >> prec_r);
        prod_nxt = size_r * hi_r;
        st_nxt   = C_UPD;
      end
      C_UPD: begin
        b        = 32'(prod_r >> prec_r) - 32'd1;
        lown     = low_r + a_r;
        low_nxt  = lown;
        rng_nxt  = b - a_r;
        wrap_nxt = (lown < a_r);
        st_nxt   = C_DEC;
      end
      C_DEC: begin
        sum = {1'b0, low_r} + {1'b0, rng_r};
        if (sum[32]) begin
          // interval straddles the top: grow the carry run
          if (rng_r[31:16] == 16'd0) begin
            low_nxt = {low_r[15:0], 16'd0};
            rng_nxt = {rng_r[15:0], 16'hFFFF};
            run_nxt = (run_r > 16'hFFFD) ? 16'hFFFF : run_r + 16'd2;
          end
        end else begin
          // release the deferred word and its run
          if (pw_r != 16'd0) begin
            w    = wrap_r ? pw_r : pw_r - 16'd1;
            fill = wrap_r ? 8'h00 : 8'hFF;
            sb_nxt[k] = w[15:8];
            sr_nxt[k] = 16'd1;
            k = k + 3'd1;
            sb_nxt[k] = w[7:0];
            sr_nxt[k] = 16'd1;
            k = k + 3'd1;
            if (run_r != 16'd0) begin
              sb_nxt[k] = fill;
              sr_nxt[k] = run_r;
              k = k + 3'd1;
            end
            pw_nxt  = '0;
            run_nxt = '0;
          end
          // renormalize by 16 bits
          if (rng_r[31:16] == 16'd0) begin
            top = low_r[31:16];
            nl  = {low_r[15:0], 16'd0};
            nr  = {rng_r[15:0], 16'hFFFF};
            low_nxt = nl;
            rng_nxt = nr;
            sum = {1'b0, nl} + {1'b0, nr};
            if (!sum[32]) begin
              sb_nxt[k] = top[15:8];
              sr_nxt[k] = 16'd1;
              k = k + 3'd1;
              sb_nxt[k] = top[7:0];
              sr_nxt[k] = 16'd1;
              k = k + 3'd1;
            end else begin
              pw_nxt  = top + 16'd1;
              run_nxt = '0;
            end
          end
        end
        cnt_nxt = k;
        idx_nxt = '0;
        st_nxt  = C_EMIT;
      end
      C_EMIT: begin
        // hand the collected bytes over one at a time
        if (idx_r == cnt_r) begin
          done   = 1'b1;
          st_nxt = C_IDLE;
        end else begin
          emit.valid = 1'b1;
          emit.data  = sb_r[idx_r];
          emit.rep   = sr_r[idx_r];
          if (emit_ok) begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: st_nxt = C_IDLE;
    endcase
  end

  // control and coder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= C_IDLE;
      low_r <= '0;
      rng_r <= '1;
      pw_r  <= '0;
      run_r <= '0;
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      st_r  <= st_nxt;
      low_r <= low_nxt;
      rng_r <= rng_nxt;
      pw_r  <= pw_nxt;
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    wrap_r <= wrap_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    prec_r <= prec_nxt;
    size_r <= size_nxt;
    prod_r <= prod_nxt;
    a_r    <= a_nxt;
    sb_r   <= sb_nxt;
    sr_r   <= sr_nxt;
  end

endmodule

FILE: rtl/cdfre_out.sv
// ----------------------------------------------------------------------------
// cdfre_out
// Output stage: holds one item back so the final item of an input can be
// marked, and drives the result channel from a register.
// ----------------------------------------------------------------------------
module cdfre_out (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cdfre_pkg::cdfre_emit_t emit,
  input  logic                   fin,
  output logic                   emit_ok,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [23:0]            out_tdata,  // out_byte[7:0], repeat_res[23:8]
  output logic                   out_tlast   // last
);
  import cdfre_pkg::*;

  logic        hv_r, hv_nxt;
  logic [7:0]  hb_r, hb_nxt;
  logic [15:0] hr_r, hr_nxt;
  logic        ov_r, ov_nxt;
  logic [23:0] od_r, od_nxt;
  logic        ol_r, ol_nxt;
  logic        out_free;

  assign out_free = !ov_r || out_tready;
  assign emit_ok  = !hv_r || out_free;

  // hold register feeds the output register
  always_comb begin
    hv_nxt = hv_r;
    hb_nxt = hb_r;
    hr_nxt = hr_r;
    ov_nxt = ov_r && !out_tready;
    od_nxt = od_r;
    ol_nxt = ol_r;
    if (emit.valid && emit_ok) begin
      if (hv_r) begin
        ov_nxt = 1'b1;
        od_nxt = {hr_r, hb_r};
        ol_nxt = 1'b0;
      end
      hv_nxt = 1'b1;
      hb_nxt = emit.data;
      hr_nxt = emit.rep;
    end else if (fin && emit_ok) begin
      if (hv_r) begin
        ov_nxt = 1'b1;
        od_nxt = {hr_r, hb_r};
        ol_nxt = 1'b1;
      end
      hv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      hv_r <= hv_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hb_r <= hb_nxt;
    hr_r <= hr_nxt;
    od_r <= od_nxt;
    ol_r <= ol_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

endmodule

FILE: rtl/cdf_range_encoder_with_escape_core.sv
// ----------------------------------------------------------------------------
// cdf_range_encoder_with_escape_core
// Range encoder over loaded cdf tables with escape coding of overflow values.
// ----------------------------------------------------------------------------
// Usage: items arrive on the in_ channel, kind in in_tuser (opcode). Cdf
// entries and table length/offset loads are written into RAMs in the cycle
// the item is accepted and give no result. An encode item reads the table
// length/offset RAM, then two cdf entries, then runs the interval coder,
// which offers the produced bytes one at a time. An escape first counts the
// overflow sections, then adds one coder pass for the count and one per
// section (up to nine passes). Finish flushes low or the deferred word and
// clears the coder; the tables keep their contents.
// Results are bytes with a repeat count on the out_ channel; out_tlast marks
// the final item caused by an input. A stalled receiver stalls the coder
// once the hold and output registers are full; no item is lost.
// Reset clears the coder and the registers; table RAMs are not cleared and
// must be loaded before use. The user must write configuration through cfg_
// while the block is idle; the block itself does not enforce this. One
// input item is in work at a time.
// ----------------------------------------------------------------------------
module cdf_range_encoder_with_escape_core #(
  parameter int NUM_TABLES  = 64,
  parameter int MAX_CDF_LEN = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // table_index[5:0], entry_index[11:6], entry_value[28:12],
  // table_length[35:29], table_offset[51:36], data_value[83:52]
  input  logic [87:0] in_tdata,
  input  logic [1:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_byte[7:0], repeat_res[23:8]
  output logic        out_tlast,  // last
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_wdata
);
  import cdfre_pkg::*;

  localparam int TAW = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int SW  = $clog2(MAX_CDF_LEN);
  localparam int CD  = NUM_TABLES * MAX_CDF_LEN;
  localparam int CAW = $clog2(CD);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_MAP  = 11'b00000000010,
    S_SYM  = 11'b00000000100,
    S_RD0  = 11'b00000001000,
    S_RD1  = 11'b00000010000,
    S_HI   = 11'b00000100000,
    S_WAIT = 11'b00001000000,
    S_CNT  = 11'b00010000000,
    S_ESCW = 11'b00100000000,
    S_ESCS = 11'b01000000000,
    S_END  = 11'b10000000000
  } st_t;

  // input fields
  logic [1:0]  f_op;
  logic [5:0]  f_t;
  logic [5:0]  f_e;
  logic [16:0] f_ev;
  logic [6:0]  f_len;
  logic [15:0] f_off;
  logic [31:0] f_dv;
  assign f_op  = in_tuser;
  assign f_t   = in_tdata[5:0];
  assign f_e   = in_tdata[11:6];
  assign f_ev  = in_tdata[28:12];
  assign f_len = in_tdata[35:29];
  assign f_off = in_tdata[51:36];
  assign f_dv  = in_tdata[83:52];

  st_t          st_r, st_nxt;
  logic [4:0]   prec_r;
  logic [3:0]   esc_r;
  logic [5:0]   t_r, t_nxt;
  logic [31:0]  dv_r, dv_nxt;
  logic [31:0]  v_r, v_nxt;
  logic [SW-1:0] maxv_r, maxv_nxt;
  logic [SW-1:0] sym_r, sym_nxt;
  logic [31:0]  ovf_r, ovf_nxt;
  logic         escf_r, escf_nxt;
  logic [16:0]  lo_r, lo_nxt;
  logic [31:0]  sh_r, sh_nxt;
  logic [3:0]   n_r, n_nxt;
  logic [3:0]   j_r, j_nxt;

  logic         accept;
  logic         t_ok;
  logic         cdf_we;
  logic         tab_we;
  logic [CAW-1:0] cdf_waddr;
  logic [CAW-1:0] cdf_raddr;
  logic [16:0]  cdf_rdata;
  logic [6:0]   len_rdata;
  logic [15:0]  off_rdata;
  logic [4:0]   prec_c;
  logic [3:0]   ew_c;
  logic [7:0]   maxov;

  cdfre_cmd_t   cmd;
  cdfre_emit_t  emit;
  logic         emit_ok;
  logic         cdone;
  logic         fin;

  assign accept = in_tvalid && in_tready;
  assign t_ok   = (32'(f_t) < NUM_TABLES);
  assign cdf_we = accept && (f_op == OP_CDF) && t_ok && (32'(f_e) < MAX_CDF_LEN);
  assign tab_we = accept && (f_op == OP_LEN) && t_ok;
  assign cdf_waddr = CAW'(32'(f_t) * MAX_CDF_LEN + 32'(f_e));
  assign cdf_raddr = CAW'(32'(t_r) * MAX_CDF_LEN + 32'(sym_r)
                          + ((st_r == S_RD1) ? 32'd1 : 32'd0));

  // saturated configuration values
  assign prec_c = (prec_r < 5'd1) ? 5'd1 : ((prec_r > 5'd16) ? 5'd16 : prec_r);
  assign ew_c   = (esc_r < 4'd4) ? 4'd4 : ((esc_r > 4'd8) ? 4'd8 : esc_r);
  assign maxov  = 8'((9'd1 << ew_c) - 9'd1);

  // table memories
  cdfre_ram #(.W(17), .D(CD)) u_cdf_ram (
    .clk   (clk),
    .we    (cdf_we),
    .waddr (cdf_waddr),
    .wdata (f_ev),
    .raddr (cdf_raddr),
    .rdata (cdf_rdata)
  );

  cdfre_ram #(.W(7), .D(NUM_TABLES)) u_len_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (TAW'(f_t)),
    .wdata (f_len),
    .raddr (TAW'(f_t)),
    .rdata (len_rdata)
  );

  cdfre_ram #(.W(16), .D(NUM_TABLES)) u_off_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (TAW'(f_t)),
    .wdata (f_off),
    .raddr (TAW'(f_t)),
    .rdata (off_rdata)
  );

  // item sequencer
  always_comb begin
    logic [10:0] len;
    logic [31:0] maxv32;
    logic [7:0]  s;
    st_nxt   = st_r;
    t_nxt    = t_r;
    dv_nxt   = dv_r;
    v_nxt    = v_r;
    maxv_nxt = maxv_r;
    sym_nxt  = sym_r;
    ovf_nxt  = ovf_r;
    escf_nxt = escf_r;
    lo_nxt   = lo_r;
    sh_nxt   = sh_r;
    n_nxt    = n_r;
    j_nxt    = j_r;
    cmd      = '0;
    fin      = 1'b0;
    in_tready = (st_r == S_IDLE);
    len = '0; maxv32 = '0; s = '0;
    unique case (st_r)
      S_IDLE: begin
        if (accept) begin
          t_nxt  = f_t;
          dv_nxt = f_dv;
          if (f_op == OP_ENC && t_ok) begin
            st_nxt = S_MAP;
          end else if (f_op == OP_FIN) begin
            cmd.finish = 1'b1;
            escf_nxt   = 1'b0;
            st_nxt     = S_WAIT;
          end
        end
      end
      S_MAP: begin
        // clamp the length and remove the offset
        len = 11'(len_rdata);
        if (len < 11'd2) len = 11'd2;
        if (32'(len) > MAX_CDF_LEN) len = 11'(MAX_CDF_LEN);
        maxv_nxt = SW'(len - 11'd2);
        v_nxt    = dv_r - {{16{off_rdata[15]}}, off_rdata};
        st_nxt   = S_SYM;
      end
      S_SYM: begin
        // pick the symbol and the zigzag overflow code
        maxv32 = 32'(maxv_r);
        if (v_r[31]) begin
          ovf_nxt = ~{v_r[30:0], 1'b0};
          sym_nxt = maxv_r;
        end else if (v_r >= maxv32) begin
          ovf_nxt = {v_r[30:0] - maxv32[30:0], 1'b0};
          sym_nxt = maxv_r;
        end else begin
          ovf_nxt = '0;
          sym_nxt = SW'(v_r);
        end
        escf_nxt = v_r[31] || (v_r >= maxv32);
        st_nxt   = S_RD0;
      end
      S_RD0: st_nxt = S_RD1;
      S_RD1: begin
        lo_nxt = cdf_rdata;
        st_nxt = S_HI;
      end
      S_HI: begin
        cmd.start = 1'b1;
        cmd.lo    = lo_r;
        cmd.hi    = cdf_rdata;
        cmd.prec  = prec_c;
        st_nxt    = S_WAIT;
      end
      S_WAIT: begin
        if (cdone) begin
          sh_nxt = ovf_r;
          n_nxt  = '0;
          st_nxt = escf_r ? S_CNT : S_END;
        end
      end
      S_CNT: begin
        // count sections; at most eight, so the count fits one symbol
        if (sh_r != 32'd0) begin
          sh_nxt = sh_r >> ew_c;
          n_nxt  = n_r + 4'd1;
        end else begin
          cmd.start = 1'b1;
          cmd.lo    = 17'(n_r);
          cmd.hi    = 17'(n_r) + 17'd1;
          cmd.prec  = 5'(ew_c);
          sh_nxt    = ovf_r;
          j_nxt     = '0;
          st_nxt    = S_ESCW;
        end
      end
      S_ESCW: begin
        if (cdone) begin
          st_nxt = S_ESCS;
        end
      end
      S_ESCS: begin
        // sections from least significant up
        if (j_r == n_r) begin
          st_nxt = S_END;
        end else begin
          s = sh_r[7:0] & maxov;
          cmd.start = 1'b1;
          cmd.lo    = 17'(s);
          cmd.hi    = 17'(s) + 17'd1;
          cmd.prec  = 5'(ew_c);
          sh_nxt    = sh_r >> ew_c;
          j_nxt     = j_r + 4'd1;
          st_nxt    = S_ESCW;
        end
      end
      S_END: begin
        fin = 1'b1;
        if (emit_ok) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      prec_r <= 5'd16;
      esc_r  <= 4'd4;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PREC: prec_r <= cfg_wdata;
          REG_ESC:  esc_r  <= cfg_wdata[3:0];
          default:  ;
        endcase
      end
    end
  end

  // item working registers
  always_ff @(posedge clk) begin
    t_r    <= t_nxt;
    dv_r   <= dv_nxt;
    v_r    <= v_nxt;
    maxv_r <= maxv_nxt;
    sym_r  <= sym_nxt;
    ovf_r  <= ovf_nxt;
    escf_r <= escf_nxt;
    lo_r   <= lo_nxt;
    sh_r   <= sh_nxt;
    n_r    <= n_nxt;
    j_r    <= j_nxt;
  end

  cdfre_coder u_coder (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .emit_ok (emit_ok),
    .emit    (emit),
    .done    (cdone)
  );

  cdfre_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit       (emit),
    .fin        (fin),
    .emit_ok    (emit_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: tb/sv/cdf_range_encoder_with_escape_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cdf_range_encoder_with_escape_core_tb
// Loads cdf tables, encodes directed and random values under several
// precision and escape-width settings with random gaps and receiver stalls,
// and checks every output byte, repeat count and last flag against a
// behavioral coder model kept in a scoreboard.
// ----------------------------------------------------------------------------
module cdf_range_encoder_with_escape_core_tb;
  import cdfre_pkg::*;

  localparam int NTAB  = 64;
  localparam int NENT  = 64;
  localparam int MAXRES = 50;

  typedef struct {
    logic [7:0]  code_byte;
    logic [15:0] rep;
    logic        last;
  } coded_byte_t;

  // ------------------------------------------------------------------------
  // coder model and expected byte store
  // ------------------------------------------------------------------------
  class coder_scoreboard;
    bit [4:0]    prec_reg;
    bit [3:0]    esc_reg;
    bit [31:0]   low;
    bit [31:0]   rng1;
    bit [15:0]   pend_word;
    bit [15:0]   pend_run;
    bit [16:0]   cdf_mem [NTAB*NENT];
    bit [6:0]    len_mem [NTAB];
    bit [15:0]   off_mem [NTAB];
    coded_byte_t expected_bytes[$];
    coded_byte_t step_bytes[$];
    int          errors;

    function new();
      prec_reg = 16;
      esc_reg = 4;
      clear_coder();
      errors = 0;
    endfunction

    function void clear_coder();
      low = 0;
      rng1 = 32'hFFFF_FFFF;
      pend_word = 0;
      pend_run = 0;
    endfunction

    function void set_reg(logic idx, bit [4:0] val);
      if (idx == REG_PREC) prec_reg = val;
      else esc_reg = val[3:0];
    endfunction

    function void emit(bit [7:0] b, bit [15:0] r);
      coded_byte_t c;
      if (step_bytes.size() >= MAXRES) return;
      c.code_byte = b;
      c.rep = r;
      c.last = 0;
      step_bytes.push_back(c);
    endfunction

    // narrow the interval to [lo,hi) out of 2^p, renormalize 16 bits at a time
    function void code_interval(bit [31:0] lo, bit [31:0] hi, int p);
      bit [31:0] full, a, b, top, w;
      longint unsigned sz;
      bit wrapped;
      full = 32'd1 << p;
      if (lo > full) lo = full;
      if (hi > full) hi = full;
      if (hi <= lo) begin
        if (lo >= full) begin
          lo = full - 1;
          hi = full;
        end else hi = lo + 1;
      end
      sz = longint'(rng1) + 1;
      a = 32'((sz * lo) >> p);
      b = 32'(((sz * hi) >> p) - 1);
      low = low + a;
      rng1 = b - a;
      wrapped = low < a;
      // still straddling the 2^32 boundary: grow the carry run
      if (32'(low + rng1) < low) begin
        if ((rng1 >> 16) == 0) begin
          low = low << 16;
          rng1 = (rng1 << 16) | 32'hFFFF;
          pend_run = (pend_run > 16'hFFFD) ? 16'hFFFF : pend_run + 2;
        end
        return;
      end
      // release the deferred word and its run
      if (pend_word != 0) begin
        w = wrapped ? pend_word : pend_word - 1;
        emit(w[15:8], 1);
        emit(w[7:0], 1);
        if (pend_run != 0) emit(wrapped ? 8'h00 : 8'hFF, pend_run);
        pend_word = 0;
        pend_run = 0;
      end
      if ((rng1 >> 16) == 0) begin
        top = low >> 16;
        low = low << 16;
        rng1 = (rng1 << 16) | 32'hFFFF;
        if (low <= 32'(low + rng1)) begin
          emit(top[15:8], 1);
          emit(top[7:0], 1);
        end else begin
          pend_word = 16'(top + 1);
          pend_run = 0;
        end
      end
    endfunction

    // accepted input item: work out its coded bytes
    function void note_item(logic [1:0] op, logic [87:0] d);
      bit [5:0]  t;
      bit [31:0] p, ew, maxov, len, maxv, off, v, ovf, sym, n, cnt, s, mid;
      coded_byte_t c;
      t = d[5:0];
      step_bytes.delete();
      case (op)
        OP_CDF: cdf_mem[t*NENT + d[11:6]] = d[28:12];
        OP_LEN: begin
          len_mem[t] = d[35:29];
          off_mem[t] = d[51:36];
        end
        OP_ENC: begin
          p = prec_reg < 1 ? 1 : (prec_reg > 16 ? 16 : prec_reg);
          ew = esc_reg < 4 ? 4 : (esc_reg > 8 ? 8 : esc_reg);
          maxov = (32'd1 << ew) - 1;
          len = len_mem[t];
          if (len < 2) len = 2;
          if (len > NENT) len = NENT;
          maxv = len - 2;
          off = {{16{off_mem[t][15]}}, off_mem[t]};
          v = d[83:52] - off;
          sym = v;
          ovf = 0;
          // negative, top symbol or above: escape with zigzag overflow
          if (v[31]) begin
            ovf = 0 - 2*v - 1;
            sym = maxv;
          end else if (v >= maxv) begin
            ovf = 2*(v - maxv);
            sym = maxv;
          end
          code_interval(cdf_mem[t*NENT + sym], cdf_mem[t*NENT + sym + 1], p);
          if (sym == maxv) begin
            n = 0;
            while (n*ew < 32 && (ovf >> (n*ew)) != 0) n++;
            cnt = n;
            while (cnt >= maxov) begin
              code_interval(maxov, maxov + 1, ew);
              cnt -= maxov;
            end
            code_interval(cnt, cnt + 1, ew);
            for (int j = 0; j < n; j++) begin
              s = (ovf >> (j*ew)) & maxov;
              code_interval(s, s + 1, ew);
            end
          end
        end
        default: begin
          // flush the deferred word or the middle of the interval
          if (pend_word != 0) begin
            emit(pend_word[15:8], 1);
            if (pend_word[7:0] != 0) emit(pend_word[7:0], 1);
          end else if (low != 0) begin
            mid = (((low - 1) >> 16) + 1) & 32'hFFFF;
            emit(mid[15:8], 1);
            if (mid[7:0] != 0) emit(mid[7:0], 1);
          end
          clear_coder();
        end
      endcase
      if (step_bytes.size() > 0) step_bytes[step_bytes.size()-1].last = 1;
      foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_byte(logic [7:0] b, logic [15:0] r, logic l);
      coded_byte_t e;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected byte %h rep %0d last %b", b, r, l));
        return;
      end
      e = expected_bytes.pop_front();
      if (b !== e.code_byte) report($sformatf("byte %h, want %h", b, e.code_byte));
      if (r !== e.rep) report($sformatf("repeat %0d, want %0d", r, e.rep));
      if (l !== e.last) report($sformatf("last %b, want %b", l, e.last));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we;
  logic        cfg_index;
  logic [4:0]  cfg_wdata;

  coder_scoreboard sb = new();

  // tables the stimulus may encode with
  bit        entry_set [NTAB][NENT];
  bit        len_set [NTAB];
  int        eff_len [NTAB];
  bit [15:0] tab_off [NTAB];
  int        burst_left;
  int        hold_req;
  int        hold_seen;
  int        hold_cnt;
  int        rx_mode;
  int        rx_cycle;

  cdf_range_encoder_with_escape_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial clk = 0;
  always #6 clk = ~clk;

  // watchdog
  initial begin
    #10ms;
    $display("TB_ERROR");
    $finish;
  end

  // receiver: check items, stall on a changing pattern, long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
      hold_seen <= 0;
      hold_cnt <= 0;
      rx_mode <= 0;
      rx_cycle <= 0;
    end else begin
      if (out_tvalid && out_tready)
        sb.check_byte(out_tdata[7:0], out_tdata[23:8], out_tlast);
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 2);
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_cnt <= 400;
        out_tready <= 0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_tready <= 0;
      end else begin
        case (rx_mode)
          0: out_tready <= 1;
          1: out_tready <= $urandom_range(0, 1);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // offer one item, hold until accepted, then maybe start a gap
  task automatic send_item(logic [1:0] op, logic [87:0] d);
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, d);
    if (burst_left > 0) burst_left--;
    else begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic write_entry(int t, int e, bit [16:0] val);
    send_item(OP_CDF, {36'd0, 16'd0, 7'd0, val, 6'(e), 6'(t)});
    entry_set[t][e] = 1;
  endtask

  task automatic write_len(int t, bit [6:0] len, bit [15:0] off);
    send_item(OP_LEN, {36'd0, off, len, 17'd0, 6'd0, 6'(t)});
    len_set[t] = 1;
    eff_len[t] = len < 2 ? 2 : (len > NENT ? NENT : len);
    tab_off[t] = off;
  endtask

  task automatic encode(int t, bit [31:0] val);
    send_item(OP_ENC, {4'd0, val, 16'd0, 7'd0, 17'd0, 6'd0, 6'(t)});
  endtask

  task automatic finish_stream();
    send_item(OP_FIN, {$urandom, $urandom, 24'(($urandom))});
  endtask

  // monotonic table, with a few odd entries
  task automatic load_table(int t, bit [6:0] len, bit [15:0] off);
    int n;
    bit [16:0] val;
    write_len(t, len, off);
    n = eff_len[t];
    for (int e = 0; e < n; e++) begin
      val = 17'((e * 65536) / (n - 1));
      if ($urandom_range(0, 9) == 0) val = 17'($urandom);
      write_entry(t, e, val);
    end
  endtask

  function automatic bit table_ready(int t);
    if (!len_set[t]) return 0;
    for (int e = 0; e < eff_len[t]; e++)
      if (!entry_set[t][e]) return 0;
    return 1;
  endfunction

  // wait for all results, then let a possibly silent item finish
  task automatic drain();
    int guard;
    in_tvalid <= 0;
    guard = 0;
    while (sb.expected_bytes.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
  endtask

  task automatic set_cfg(logic idx, bit [4:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 0;
  endtask

  task automatic random_items(int count);
    int ready_tabs[$];
    int t, maxv, sel;
    bit [31:0] off, val;
    for (int i = 0; i < count; i++) begin
      ready_tabs.delete();
      for (int k = 0; k < NTAB; k++) if (table_ready(k)) ready_tabs.push_back(k);
      sel = $urandom_range(0, 99);
      if (sel < 70 && ready_tabs.size() > 0) begin
        t = ready_tabs[$urandom_range(0, ready_tabs.size() - 1)];
        maxv = eff_len[t] - 2;
        off = {{16{tab_off[t][15]}}, tab_off[t]};
        case ($urandom_range(0, 4))
          0, 1: val = off + $urandom_range(0, maxv);
          2: val = off + maxv + $urandom_range(0, 300);
          3: val = off - $urandom_range(1, 300);
          default: val = $urandom;
        endcase
        encode(t, val);
      end else if (sel < 80) begin
        finish_stream();
      end else if (sel < 92) begin
        write_entry($urandom_range(0, NTAB - 1), $urandom_range(0, NENT - 1),
                    17'($urandom));
      end else begin
        write_len($urandom_range(0, NTAB - 1), 7'($urandom), 16'($urandom));
      end
    end
  endtask

  // main sequence
  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    in_tuser = OP_CDF;
    cfg_we = 0;
    cfg_index = REG_PREC;
    cfg_wdata = 0;
    hold_req = 0;
    burst_left = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // tables: shortest length from a length of zero, longest from 127,
    // offset extremes
    load_table(0, 7'd0, 16'h1234);
    load_table(1, 7'd127, 16'h0000);
    load_table(2, 7'd5, 16'h8000);
    load_table(3, 7'd9, 16'h7FFF);
    write_entry(3, 4, 17'h1FFFF);
    write_entry(3, 5, 17'h10000);

    // long receiver hold while the escape-heavy encodes keep coming
    hold_req++;

    // directed encodes: in range, top symbol, below zero, wrap extremes
    encode(2, 32'hFFFF_8000);
    encode(2, 32'hFFFF_8003);
    encode(2, 32'hFFFF_7FFF);
    encode(2, 32'h8000_0000);
    encode(2, 32'h7FFF_FFFF);
    encode(3, 32'h0000_7FFF + 4);
    encode(3, 32'h0000_7FFF + 5);
    encode(1, 32'd61);
    encode(0, 32'h1234);
    finish_stream();
    finish_stream();
    drain();

    // configuration phases, extremes and out-of-range values among them
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin set_cfg(REG_PREC, 5'd16); set_cfg(REG_ESC, 5'd4); end
        1: begin set_cfg(REG_PREC, 5'd1);  set_cfg(REG_ESC, 5'd8); end
        2: begin set_cfg(REG_PREC, 5'd0);  set_cfg(REG_ESC, 5'd15); end
        3: begin set_cfg(REG_PREC, 5'd31); set_cfg(REG_ESC, 5'd0); end
        default: begin
          set_cfg(REG_PREC, 5'($urandom_range(1, 16)));
          set_cfg(REG_ESC, 5'($urandom_range(4, 8)));
        end
      endcase
      // long receiver hold while items keep coming
      if (ph == 1) hold_req++;
      random_items(4);
      drain();
    end

    if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
      $display("TB_OK");
    end else begin
      if (sb.expected_bytes.size() != 0)
        sb.report($sformatf("%0d bytes never came", sb.expected_bytes.size()));
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/cdfre_pkg.sv
rtl/cdfre_ram.sv
rtl/cdfre_coder.sv
rtl/cdfre_out.sv
rtl/cdf_range_encoder_with_escape_core.sv
tb/sv/cdf_range_encoder_with_escape_core_tb.sv
